// File: hdl/lwot_pkg.sv
// ----------------------------------------------------------------------------
// Load window offset tuner package
// Types, widths and constants shared by the tuner's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwot_pkg;

  // Usage in unsigned Q7.8 percent; full scale is 100.0 percent.
  localparam int unsigned USAGE_W    = 15;
  localparam int unsigned FULL_SCALE = 25600;

  // Serial usage divider: the dividend's top bits are always below the divisor,
  // so a quotient of USAGE_W bits is produced in that many steps.
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned QUOT_W     = USAGE_W;
  localparam int unsigned STEP_W     = $clog2(QUOT_W + 1);

  // Configuration registers.
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] HIGH_THRESHOLD_RST = 7'd70;
  localparam logic [CFG_DATA_W-1:0] LOW_THRESHOLD_RST  = 7'd20;

  // Interval offset limits.
  localparam logic signed [7:0] OFFSET_MIN = 8'sh80;

  typedef logic [USAGE_W-1:0] usage_t;
  typedef logic signed [7:0]  offset_t;

  // Control of the sample ring memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } ring_ctl_t;

endpackage

`default_nettype wire

// File: hdl/lwot_in_if.sv
// ----------------------------------------------------------------------------
// Load window offset tuner input channel
// Valid/ready channel carrying one load sample request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lwot_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] used_amount;
  logic [15:0] capacity;

  modport source (output valid, used_amount, capacity, input ready);
  modport sink   (input valid, used_amount, capacity, output ready);
endinterface

`default_nettype wire

// File: hdl/lwot_out_if.sv
// ----------------------------------------------------------------------------
// Load window offset tuner result channel
// Valid/ready channel carrying one tuning result request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lwot_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] interval_offset;
  logic [14:0]       average_usage;
  logic              lowered;
  logic              raised;

  modport source (output valid, interval_offset, average_usage, lowered, raised,
                  input ready);
  modport sink   (input valid, interval_offset, average_usage, lowered, raised,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/lwot_div.sv
// ----------------------------------------------------------------------------
// Load window offset tuner serial divider
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the dividend's upper bits are below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwot_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lwot_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [lwot_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                done,
  output logic [lwot_pkg::QUOT_W-1:0]          quotient
);
  import lwot_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    cnt_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] div_r;
  logic [QUOT_W-1:0]    num_r;
  logic [QUOT_W-1:0]    quo_r;

  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W-1:0] rem_nxt;

  assign trial   = {rem_r, num_r[QUOT_W-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign rem_nxt = ge ? DIVISOR_W'(trial - {1'b0, div_r}) : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVIDEND_W-1:QUOT_W];
      num_r <= dividend[QUOT_W-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[QUOT_W-2:0], 1'b0};
      quo_r <= {quo_r[QUOT_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hdl/lwot_ring.sv
// ----------------------------------------------------------------------------
// Load window offset tuner sample ring
// Synchronous memory of recent usage samples with a registered read port.
// Per-entry valid bits make a cleared entry read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwot_ring #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lwot_pkg::ring_ctl_t  ctl,
  input  wire logic [ADDR_W-1:0]    addr,
  input  wire lwot_pkg::usage_t     wr_data,
  output lwot_pkg::usage_t          rd_data
);
  import lwot_pkg::*;

  usage_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  usage_t           mem_q_r;
  logic             vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        vld_q_r <= valid_r[addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

`default_nettype wire

// File: hdl/load_window_offset_tuner_unit.sv
// A request is taken when the block is idle and passes the load, usage divide
// (skipped when the used amount reaches capacity), ring update, average and
// decision steps; the next is taken only once its result is presented. The
// usage divider gives one bit per cycle; the average is a reciprocal multiply.
// Reset (rst_n, synchronous, active low) clears the ring, offset and counters,
// and restores the thresholds to 70 and 20 percent.
// ----------------------------------------------------------------------------
// Load window offset tuner
// Tracks resource usage over a window of recent samples and moves a
// non-positive interval offset with hysteresis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_window_offset_tuner_unit #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  lwot_in_if.sink                               in_ch,
  lwot_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [lwot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lwot_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lwot_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_SIZE);
  localparam int unsigned CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW_SIZE * FULL_SCALE + 1);

  // The window average is sum * AVG_MULT >> AVG_SHIFT, where AVG_MULT is the
  // reciprocal of WINDOW_SIZE rounded up. The extra log2(WINDOW_SIZE) bits of
  // shift keep the rounding error below one step of the truncated quotient.
  localparam int unsigned AVG_SHIFT = SUM_W + $clog2(WINDOW_SIZE);
  localparam int unsigned MULT_W    = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] AVG_MULT =
    MULT_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

  // The sequencer walks one request through the multiply, the usage divide,
  // the ring update, the average scaling and the decision.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV_USE,
    S_ACC,
    S_AVG,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [CFG_DATA_W-1:0]  high_thr_r;
  logic [CFG_DATA_W-1:0]  low_thr_r;
  logic [DIVIDEND_W-1:0]  prod_r;
  logic [DIVISOR_W-1:0]   cap_r;
  logic                   sat_r;
  usage_t                 old_r;
  usage_t                 cur_r;
  usage_t                 avg_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [CNT_W-1:0]       cnt_r;
  offset_t                offset_r;

  logic                   out_valid_r;
  offset_t                out_offset_r;
  usage_t                 out_avg_r;
  logic                   out_lowered_r;
  logic                   out_raised_r;

  logic                   in_take;
  logic                   out_free;
  logic                   div_start;
  logic [DIVIDEND_W-1:0]  div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   div_done;
  usage_t                 div_quot;
  ring_ctl_t              ring_ctl;
  usage_t                 ring_rd;
  logic [SUM_W-1:0]       sum_nxt;
  logic [PROD_W-1:0]      avg_prod;
  logic                   full;
  logic                   lower_hit;
  logic                   raise_hit;
  offset_t                off_mid;
  offset_t                off_fin;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Running window sum: drop the sample being overwritten, add the new one.
  assign sum_nxt = sum_r - SUM_W'(old_r) + SUM_W'(cur_r);

  // Window average from the updated sum.
  assign avg_prod = PROD_W'(sum_r) * PROD_W'(AVG_MULT);

  // The divider forms used * 25600 / capacity, only when used is below
  // capacity, so the quotient fits. The operands were captured with the request.
  assign div_start    = (state_r == S_LOAD) && !sat_r;
  assign div_dividend = prod_r;
  assign div_divisor  = cap_r;

  lwot_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // The ring slot is read when a request is taken and written back in the
  // accumulate step; requests never overlap, so no forwarding is needed.
  assign ring_ctl.rd_en = in_take;
  assign ring_ctl.wr_en = (state_r == S_ACC);
  assign ring_ctl.clear = (state_r == S_DONE) && out_free && lower_hit;

  lwot_ring #(
    .DEPTH  (WINDOW_SIZE),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .addr    (slot_r),
    .wr_data (cur_r),
    .rd_data (ring_rd)
  );

  // Hysteresis decision. Lowering clears the history, which empties the
  // window, so a sample that lowers never also raises.
  assign full      = (cnt_r == CNT_W'(WINDOW_SIZE));
  assign lower_hit = full && (cur_r > avg_r) && (avg_r > {high_thr_r, 8'b0});
  assign off_mid   = lower_hit ? ((offset_r != OFFSET_MIN) ? offset_r - 8'sd1 : offset_r)
                               : offset_r;
  assign raise_hit = full && !lower_hit && (avg_r < {low_thr_r, 8'b0}) && off_mid[7];
  assign off_fin   = raise_hit ? off_mid + 8'sd1 : off_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THRESHOLD_RST;
      low_thr_r  <= LOW_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_THRESHOLD: high_thr_r <= cfg_wdata;
        CFG_LOW_THRESHOLD:  low_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer with its state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The finishing step sets the result valid itself when it presents one.
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            prod_r  <= DIVIDEND_W'(in_ch.used_amount) * DIVIDEND_W'(FULL_SCALE);
            cap_r   <= in_ch.capacity;
            sat_r   <= (in_ch.used_amount >= in_ch.capacity);
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // The overwritten sample arrives from the ring in this cycle.
          old_r <= ring_rd;
          if (sat_r) begin
            cur_r   <= usage_t'(FULL_SCALE);
            state_r <= S_ACC;
          end else begin
            state_r <= S_DIV_USE;
          end
        end
        S_DIV_USE: begin
          if (div_done) begin
            cur_r   <= div_quot;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r   <= sum_nxt;
          slot_r  <= (slot_r == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_r + 1'b1;
          if (!full) begin
            cnt_r <= cnt_r + 1'b1;
          end
          state_r <= S_AVG;
        end
        S_AVG: begin
          avg_r   <= avg_prod[AVG_SHIFT +: USAGE_W];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_offset_r  <= off_fin;
            out_avg_r     <= avg_r;
            out_lowered_r <= lower_hit;
            out_raised_r  <= raise_hit;
            offset_r      <= off_fin;
            if (lower_hit) begin
              sum_r  <= '0;
              slot_r <= '0;
              cnt_r  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.interval_offset = out_offset_r;
  assign out_ch.average_usage   = out_avg_r;
  assign out_ch.lowered         = out_lowered_r;
  assign out_ch.raised          = out_raised_r;

endmodule

`default_nettype wire

// File: hdl/lwot_checker.sv
// ----------------------------------------------------------------------------
// Load window offset tuner port checker
// Watches the tuner's channels and flags behavior it must never show.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwot_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [7:0] interval_offset,
  input wire logic              lowered,
  input wire logic              raised
);

  // A result waiting for its consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // Requests are worked one at a time, so the block is busy right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // Lowering clears the window, so it excludes raising in the same sample.
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(lowered && raised))
    else $error("result both lowered and raised the offset");

  // The offset never goes above zero; a raise only happens from below zero.
  a_offset_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (interval_offset[7] || interval_offset == 8'sd0))
    else $error("interval offset became positive");

endmodule

bind load_window_offset_tuner_unit lwot_checker u_lwot_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .interval_offset (out_ch.interval_offset),
  .lowered         (out_ch.lowered),
  .raised          (out_ch.raised)
);

`default_nettype wire

// File: tb/load_window_offset_tuner_unit_tb.sv
// ----------------------------------------------------------------------------
// Load window offset tuner testbench
// Feeds load samples through the input channel and checks every tuning result
// against a cycle-free model of the usage ring, the window average and the
// offset hysteresis. Directed checks of the edges come first, then a walk of
// the offset well down and back, then randomized threshold phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_window_offset_tuner_unit_tb;
  import lwot_pkg::*;

  localparam int unsigned RING_DEPTH    = 8;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned RANDOM_ITEMS  = 420;
  // Lowering windows that walk the offset a good way down.
  localparam int unsigned FLOOR_WINDOWS = 40;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned REPORT_LIMIT  = 200;

  // How the result side paces its ready line.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_CHOPPY,
    READY_BLOCKS
  } ready_mode_e;

  typedef struct packed {
    offset_t interval_offset;
    usage_t  average_usage;
    logic    lowered;
    logic    raised;
  } tuning_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HIGH_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lwot_in_if  in_ch ();
  lwot_out_if out_ch ();

  load_window_offset_tuner_unit #(
    .WINDOW_SIZE(RING_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock: 6 ns high, 6 ns low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the tuner. It is advanced once per accepted request, and its
  // thresholds follow every register write.
  // --------------------------------------------------------------------------
  usage_t                sample_ring [RING_DEPTH];
  int unsigned           ring_slot;
  int unsigned           ring_fill;
  logic [17:0]           ring_total;
  offset_t               tuned_offset;
  logic [CFG_DATA_W-1:0] high_pct;
  logic [CFG_DATA_W-1:0] low_pct;

  // Results the block still owes us, oldest first.
  tuning_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  function automatic void clear_history();
    foreach (sample_ring[i]) sample_ring[i] = '0;
    ring_slot  = 0;
    ring_fill  = 0;
    ring_total = '0;
  endfunction

  function automatic void reset_predictor();
    clear_history();
    tuned_offset = '0;
    high_pct     = HIGH_THRESHOLD_RST;
    low_pct      = LOW_THRESHOLD_RST;
  endfunction

  // Usage percent in Q7.8, truncated. A zero capacity counts as fully used,
  // and anything above capacity is clipped to full scale.
  function automatic usage_t usage_of(logic [15:0] used, logic [15:0] cap);
    logic [31:0] quotient;
    if (cap == 16'd0) return usage_t'(FULL_SCALE);
    quotient = (32'(used) * FULL_SCALE) / 32'(cap);
    if (quotient > FULL_SCALE) quotient = FULL_SCALE;
    return usage_t'(quotient);
  endfunction

  function automatic void predict_tuning(logic [15:0] used, logic [15:0] cap);
    usage_t         current;
    usage_t         average;
    tuning_result_t result;
    current    = usage_of(used, cap);
    ring_total = ring_total - 18'(sample_ring[ring_slot]) + 18'(current);
    sample_ring[ring_slot] = current;
    ring_slot  = (ring_slot + 1) % RING_DEPTH;
    if (ring_fill < RING_DEPTH) ring_fill++;
    average        = usage_t'(ring_total / RING_DEPTH);
    result.lowered = 1'b0;
    result.raised  = 1'b0;
    // Lowering needs a full ring, a sample above the average and an average
    // above the high threshold. The offset sticks at its floor, but the
    // history is cleared either way.
    if (ring_fill == RING_DEPTH && current > average && average > {high_pct, 8'd0}) begin
      if (tuned_offset != OFFSET_MIN) tuned_offset = tuned_offset - 8'sd1;
      clear_history();
      result.lowered = 1'b1;
    end
    // A clear empties the ring, so the raise test cannot pass right after it.
    if (ring_fill == RING_DEPTH && average < {low_pct, 8'd0} && tuned_offset < 0) begin
      tuned_offset  = tuned_offset + 8'sd1;
      result.raised = 1'b1;
    end
    result.interval_offset = tuned_offset;
    result.average_usage   = average;
    pending_results.push_back(result);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: each accepted result is compared with the oldest pending one.
  // Signals are sampled right at the edge, so the values seen are the ones the
  // block presented during the cycle before it.
  // --------------------------------------------------------------------------
  function automatic void compare_field(string field, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      error_count++;
      // A badly broken block would flood the log, so only the first few
      // hundred mismatches are shown.
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function automatic void check_tuning_result();
    tuning_result_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: unexpected result, expected none, actual offset %0d average %0d",
                 $time, out_ch.interval_offset, out_ch.average_usage);
      return;
    end
    want = pending_results.pop_front();
    compare_field("interval_offset", want.interval_offset, out_ch.interval_offset);
    compare_field("average_usage", want.average_usage, out_ch.average_usage);
    compare_field("lowered", want.lowered, out_ch.lowered);
    compare_field("raised", want.raised, out_ch.raised);
  endfunction

  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_level = 1'b1;

  // The receiver keeps switching at random between taking everything,
  // stalling on random single cycles, and holding ready low or high in long
  // stretches, so that stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_tuning_result();
    if (mode_left == 0) begin
      mode_left  = $urandom_range(50, 400);
      ready_mode = ready_mode_e'($urandom_range(0, 2));
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: begin
        out_ch.ready <= 1'b1;
      end
      READY_CHOPPY: begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        if (hold_left == 0) begin
          hold_left  = $urandom_range(1, 40);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_ch.ready <= hold_level;
      end
    endcase
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Sends one load sample request. Requests go out in bursts of random length;
  // most bursts are preceded by a random gap with valid low, the rest follow
  // the previous burst back to back. The request is taken at the first edge
  // where ready is high, and the model is stepped at that edge.
  task automatic send_sample(input logic [15:0] used, input logic [15:0] cap);
    int unsigned gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 48);
    end
    burst_left--;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.used_amount <= used;
    in_ch.capacity    <= cap;
    do @(posedge clk); while (!in_ch.ready);
    predict_tuning(used, cap);
  endtask

  // Sends a sample near the given percent of a random capacity. Percents above
  // 100 give a used amount at or beyond capacity.
  task automatic send_percent(input int unsigned pct);
    logic [15:0] cap;
    logic [31:0] used;
    cap  = 16'($urandom_range(1, 65535));
    used = (32'(cap) * pct) / 100;
    if (used > 32'hFFFF) used = 32'hFFFF;
    send_sample(used[15:0], cap);
  endtask

  // Drops valid at the edge that took the last request of a stretch.
  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  // Waits for every owed result, then lets the block settle.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HIGH_THRESHOLD) high_pct = value;
    else low_pct = value;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] high,
                                input logic [CFG_DATA_W-1:0] low);
    write_register(CFG_HIGH_THRESHOLD, high);
    write_register(CFG_LOW_THRESHOLD, low);
  endtask

  // Thresholds for a random phase: the extremes, exactly 100 percent, or
  // something in the working range.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 7'd100;
      2:       return 7'd127;
      default: return 7'($urandom_range(10, 90));
    endcase
  endfunction

  // A percent within ten points of the base, kept between 0 and 120.
  function automatic int unsigned jitter(int unsigned base);
    int v;
    v = int'(base) + int'($urandom_range(0, 20)) - 10;
    if (v < 0) v = 0;
    if (v > 120) v = 120;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Corners of the usage divide under the reset thresholds: empty and full,
  // the smallest and largest capacity, zero capacity, and more in use than
  // there is capacity. Nine requests also fill the ring and wrap it once.
  task automatic test_usage_extremes();
    send_sample(16'd0, 16'd1);
    send_sample(16'hFFFF, 16'd1);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'd1, 16'hFFFF);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'd0);
    send_sample(16'd40000, 16'd30000);
    send_sample(16'd32767, 16'hFFFF);
    stop_input();
    wait_idle();
  endtask

  // Heavy load on the ring left by the previous test pushes the average past
  // the default high threshold with the sample above it, so the offset drops
  // and the ring is cleared; the closing spike lands on a ring not yet refilled.
  task automatic test_lower_and_clear();
    repeat (RING_DEPTH - 1) send_sample(16'd80, 16'd100);
    send_sample(16'd100, 16'd100);
    stop_input();
    wait_idle();
  endtask

  // Light load on a refilled ring brings a negative offset back up by one per
  // request until it reaches zero, where it stays.
  task automatic test_raise_toward_zero();
    repeat (RING_DEPTH + 1) send_sample(16'd5, 16'd100);
    stop_input();
    wait_idle();
  endtask

  // With both thresholds at zero every full window that ends in a spike
  // lowers the offset, which walks it a good way down. Then thresholds past
  // 100 percent: the high one can never be exceeded and the low one raises on
  // every request once the ring is full, which walks the offset back to zero.
  task automatic test_offset_floor();
    set_thresholds(7'd0, 7'd0);
    repeat (FLOOR_WINDOWS) begin
      repeat (RING_DEPTH - 1) send_percent($urandom_range(1, 50));
      send_percent(100);
    end
    stop_input();
    wait_idle();
    set_thresholds(7'd127, 7'd127);
    repeat (RING_DEPTH + 60) send_percent($urandom_range(0, 120));
    stop_input();
    wait_idle();
  endtask

  // Random phases, each under its own pair of thresholds. Most traffic is full
  // windows of samples around a base load that end in a spike, which is what
  // gets past the fill stage and into the offset logic; the rest is windows
  // cut short and raw requests with arbitrary bits, zero capacity included.
  task automatic test_threshold_sweep();
    int unsigned sent;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned base;
    int unsigned run;
    logic [15:0] noise_cap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_thresholds(pick_threshold(), pick_threshold());
      phase_end = sent + $urandom_range(60, 140);
      while (sent < phase_end) begin
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 100);
        if (kind < 6) run = RING_DEPTH - 1;
        else if (kind < 8) run = $urandom_range(1, RING_DEPTH - 2);
        else run = 0;
        if (run == 0) begin
          noise_cap = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
          send_sample(16'($urandom), noise_cap);
          sent++;
        end else begin
          repeat (run) send_percent(jitter(base));
          send_percent($urandom_range(base, 120));
          sent += run + 1;
        end
      end
      stop_input();
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Every input is known from time zero, reset is held low at
  // the start, and each test leaves the block idle with nothing owed so the
  // next one may rewrite the thresholds.
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.used_amount = '0;
    in_ch.capacity    = 16'd1;
    out_ch.ready      = 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_usage_extremes();
    test_lower_and_clear();
    test_raise_toward_zero();
    test_offset_floor();
    test_threshold_sweep();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
